// ===== hdl/murmur3_128bit_stream_hash_top_assert.svh =====
// Assertion macros for the murmur3 stream hash
`ifndef MURMUR3_128BIT_STREAM_HASH_TOP_ASSERT_SVH
`define MURMUR3_128BIT_STREAM_HASH_TOP_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define MM3_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define MM3_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== hdl/mm3_pkg.sv =====
// Package: constants, types and mixing functions for the murmur3 stream hash
`default_nettype none
package mm3_pkg;
    localparam int LENGTH_BITS = 31;
    localparam logic [63:0] MUL_A = 64'h87c37b91114253d5;
    localparam logic [63:0] MUL_B = 64'h4cf5ad432745937f;
    localparam logic [63:0] ADD_ONE = 64'h0000000052dce729;
    localparam logic [63:0] ADD_TWO = 64'h0000000038495ab5;
    localparam logic [63:0] FIN_A = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FIN_B = 64'hc4ceb9fe1a85ec53;
    localparam logic [31:0] SEED_RESET = 32'hc70f6907;

    // classified word handed from front to back
    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  count;
        logic        last;
    } t_word;

    function automatic logic [63:0] rotl(input logic [63:0] v, input int s);
        rotl = (v << s) | (v >> (64 - s));
    endfunction

    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '1;
        if (n < 4'd8) m = ~(m << {n[2:0], 3'b000});
        byte_mask = m;
    endfunction
endpackage
`default_nettype wire

// ===== hdl/mm3_front.sv =====
// Front end: word intake, byte count clamp and two-entry queue
`default_nettype none
module mm3_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [63:0]   i_lo,
    input  wire logic [63:0]   i_hi,
    input  wire logic [4:0]    i_count,
    input  wire logic          i_last,
    output logic               o_valid,
    input  wire logic          i_ready,
    output mm3_pkg::t_word     o_word
);
    mm3_pkg::t_word r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    mm3_pkg::t_word  w_in;
    logic            w_push, w_pop;

    always_comb begin
        w_in.lo    = i_lo;
        w_in.hi    = i_hi;
        w_in.last  = i_last;
        w_in.count = (!i_last || i_count > 5'd16) ? 5'd16 : i_count;
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_in;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

// ===== hdl/mm3_back.sv =====
// Back end: lane mixing sequencer, length tracking and finalisation
`default_nettype none
module mm3_back #(
    parameter int LENGTH_BITS = mm3_pkg::LENGTH_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [31:0]   i_seed,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire mm3_pkg::t_word i_word,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [63:0]        o_h1,
    output logic [63:0]        o_h2,
    output logic               o_err
);
    typedef enum logic [4:0] {
        S_IDLE, S_KMA, S_KMB, S_L1, S_L2, S_L3, S_L4, S_TAIL, S_FLEN, S_FA1, S_FA2,
        S_FX1, S_FMA, S_FMB, S_FA3, S_FA4, S_OUT
    } t_state;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    t_state                 r_state;
    logic [1:0]             r_ph;
    logic [63:0]            r_h1, r_h2, r_k1, r_k2, r_p1, r_p2;
    logic [LENGTH_BITS-1:0] r_len;
    logic                   r_ovf, r_last, r_full;
    logic                   r_valid;
    logic                   w_kmul, w_mul;
    logic [63:0]            w_x1, w_x2, w_c1, w_c2, w_pp1, w_pp2, w_r1, w_r2;
    logic [31:0]            w_a1, w_b1, w_a2, w_b2;
    logic [63:0]            w_lo_m, w_hi_m;
    logic [3:0]             w_hi_n;
    logic [LENGTH_BITS:0]   w_tot;
    logic                   w_start;

    function automatic logic [63:0] xs33(input logic [63:0] v);
        xs33 = v ^ (v >> 33);
    endfunction

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;
    assign o_h1    = r_h1;
    assign o_h2    = r_h2;
    assign o_err   = r_ovf;
    assign w_start = (r_len == '0) && !r_ovf;
    assign w_tot   = {1'b0, r_len} + (LENGTH_BITS+1)'(i_word.count);
    assign w_hi_n  = (i_word.count > 5'd8) ? 4'(i_word.count - 5'd8) : 4'd0;
    assign w_lo_m  = i_word.lo & mm3_pkg::byte_mask(i_word.count[3:0]);
    assign w_hi_m  = i_word.hi & mm3_pkg::byte_mask(w_hi_n);

    // 64x64 low product from partial products lo*lo, lo*hi, hi*lo, one 32x32 multiplier per lane
    always_comb begin
        w_kmul = (r_state == S_KMA) || (r_state == S_KMB);
        w_mul  = w_kmul || (r_state == S_FMA) || (r_state == S_FMB);
        w_x1   = w_kmul ? r_k1 : r_h1;
        w_x2   = w_kmul ? r_k2 : r_h2;
        case (r_state)
            S_KMA: begin
                w_c1 = mm3_pkg::MUL_A;
                w_c2 = mm3_pkg::MUL_B;
            end
            S_KMB: begin
                w_c1 = mm3_pkg::MUL_B;
                w_c2 = mm3_pkg::MUL_A;
            end
            S_FMA: begin
                w_c1 = mm3_pkg::FIN_A;
                w_c2 = mm3_pkg::FIN_A;
            end
            default: begin
                w_c1 = mm3_pkg::FIN_B;
                w_c2 = mm3_pkg::FIN_B;
            end
        endcase
        case (r_ph)
            2'd0: begin
                w_a1 = w_x1[31:0];
                w_b1 = w_c1[31:0];
                w_a2 = w_x2[31:0];
                w_b2 = w_c2[31:0];
            end
            2'd1: begin
                w_a1 = w_x1[31:0];
                w_b1 = w_c1[63:32];
                w_a2 = w_x2[31:0];
                w_b2 = w_c2[63:32];
            end
            default: begin
                w_a1 = w_x1[63:32];
                w_b1 = w_c1[31:0];
                w_a2 = w_x2[63:32];
                w_b2 = w_c2[31:0];
            end
        endcase
        w_pp1 = 64'(w_a1) * 64'(w_b1);
        w_pp2 = 64'(w_a2) * 64'(w_b2);
        w_r1  = {r_p1[63:32] + w_pp1[31:0], r_p1[31:0]};
        w_r2  = {r_p2[63:32] + w_pp2[31:0], r_p2[31:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= 2'd0;
            r_valid <= 1'b0;
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_last  <= 1'b0;
            r_full  <= 1'b0;
            r_h1    <= {32'd0, mm3_pkg::SEED_RESET};
            r_h2    <= {32'd0, mm3_pkg::SEED_RESET};
            r_k1    <= 64'd0;
            r_k2    <= 64'd0;
            r_p1    <= 64'd0;
            r_p2    <= 64'd0;
        end else begin
            if (w_mul) begin
                r_ph <= (r_ph == 2'd2) ? 2'd0 : r_ph + 2'd1;
                if (r_ph == 2'd0) begin
                    r_p1 <= w_pp1;
                    r_p2 <= w_pp2;
                end else begin
                    r_p1 <= w_r1;
                    r_p2 <= w_r2;
                end
            end
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    if (w_start) begin
                        r_h1 <= {32'd0, i_seed};
                        r_h2 <= {32'd0, i_seed};
                    end
                    if (w_tot > {1'b0, LEN_MAX}) begin
                        r_len <= LEN_MAX;
                        r_ovf <= 1'b1;
                    end else begin
                        r_len <= w_tot[LENGTH_BITS-1:0];
                    end
                    r_last  <= i_word.last;
                    r_full  <= (i_word.count == 5'd16);
                    r_k1    <= (i_word.count == 5'd16) ? i_word.lo : w_lo_m;
                    r_k2    <= (i_word.count == 5'd16) ? i_word.hi : w_hi_m;
                    r_state <= S_KMA;
                end
                S_KMA: if (r_ph == 2'd2) begin
                    r_k1    <= mm3_pkg::rotl(w_r1, 31);
                    r_k2    <= mm3_pkg::rotl(w_r2, 33);
                    r_state <= S_KMB;
                end
                S_KMB: if (r_ph == 2'd2) begin
                    r_k1    <= w_r1;
                    r_k2    <= w_r2;
                    r_state <= r_full ? S_L1 : S_TAIL;
                end
                S_L1: begin
                    r_h1    <= mm3_pkg::rotl(r_h1 ^ r_k1, 27) + r_h2;
                    r_state <= S_L2;
                end
                S_L2: begin
                    r_h1    <= {r_h1[61:0], 2'b00} + r_h1 + mm3_pkg::ADD_ONE;
                    r_state <= S_L3;
                end
                S_L3: begin
                    r_h2    <= mm3_pkg::rotl(r_h2 ^ r_k2, 31) + r_h1;
                    r_state <= S_L4;
                end
                S_L4: begin
                    r_h2    <= {r_h2[61:0], 2'b00} + r_h2 + mm3_pkg::ADD_TWO;
                    r_state <= r_last ? S_FLEN : S_IDLE;
                end
                // partial last block: zero keys leave a lane unchanged
                S_TAIL: begin
                    r_h1    <= r_h1 ^ r_k1;
                    r_h2    <= r_h2 ^ r_k2;
                    r_state <= S_FLEN;
                end
                S_FLEN: begin
                    r_h1    <= r_h1 ^ 64'(r_len);
                    r_h2    <= r_h2 ^ 64'(r_len);
                    r_state <= S_FA1;
                end
                S_FA1: begin
                    r_h1    <= r_h1 + r_h2;
                    r_state <= S_FA2;
                end
                S_FA2: begin
                    r_h2    <= r_h2 + r_h1;
                    r_state <= S_FX1;
                end
                S_FX1: begin
                    r_h1    <= xs33(r_h1);
                    r_h2    <= xs33(r_h2);
                    r_state <= S_FMA;
                end
                S_FMA: if (r_ph == 2'd2) begin
                    r_h1    <= xs33(w_r1);
                    r_h2    <= xs33(w_r2);
                    r_state <= S_FMB;
                end
                S_FMB: if (r_ph == 2'd2) begin
                    r_h1    <= xs33(w_r1);
                    r_h2    <= xs33(w_r2);
                    r_state <= S_FA3;
                end
                S_FA3: begin
                    r_h1    <= r_h1 + r_h2;
                    r_state <= S_FA4;
                end
                S_FA4: begin
                    r_h2    <= r_h2 + r_h1;
                    r_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: if (i_ready) begin
                    r_valid <= 1'b0;
                    r_len   <= '0;
                    r_ovf   <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "murmur3_128bit_stream_hash_top_assert.svh"
    `MM3_ASSERT_IMP(a_valid_in_out, i_clk, i_rst_n, r_valid, r_state == S_OUT)
    `MM3_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, !r_valid)
    `MM3_ASSERT_NEXT(a_take, i_clk, i_rst_n, i_valid && o_ready, r_state == S_KMA)
    `MM3_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_valid && !i_ready, r_valid && $stable(r_h1) && $stable(r_h2))
endmodule
`default_nettype wire

// ===== hdl/murmur3_128bit_stream_hash_top.sv =====
// Top level: MurmurHash3 x64 128-bit stream hash
// Each word passes a registered two-entry intake queue into a sequencer that builds every
// 64-bit product from one 32x32 multiplier per lane, partial product by partial product.
// A body word runs key and lane mixing; a last word then runs finalisation (a partial last
// block takes a tail step instead of lane mixing); the next word is taken once the result
// is accepted. A seed write applies from the next message start.
`default_nettype none
module murmur3_128bit_stream_hash_top #(
    parameter int LENGTH_BITS = mm3_pkg::LENGTH_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [31:0]   i_cfg_wdata,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [135:0]  s_axis_tdata,  // word_low, word_high, byte_count, pad
    input  wire logic          s_axis_tlast,  // last_block
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [135:0]       m_axis_tdata,  // hash_first, hash_second, length_error, pad
    output logic               m_axis_tlast
);
    logic [31:0]    r_seed;
    logic           w_v, w_r;
    mm3_pkg::t_word w_word;
    logic [63:0]    w_h1, w_h2;
    logic           w_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_seed <= mm3_pkg::SEED_RESET;
        else if (i_cfg_we) r_seed <= i_cfg_wdata;
    end

    mm3_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_lo(s_axis_tdata[63:0]), .i_hi(s_axis_tdata[127:64]),
        .i_count(s_axis_tdata[132:128]), .i_last(s_axis_tlast),
        .o_valid(w_v), .i_ready(w_r), .o_word(w_word)
    );

    mm3_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_seed(r_seed),
        .i_valid(w_v), .o_ready(w_r), .i_word(w_word),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_h1(w_h1), .o_h2(w_h2), .o_err(w_err)
    );

    assign m_axis_tdata = {7'd0, w_err, w_h2, w_h1};
    assign m_axis_tlast = 1'b1;
endmodule
`default_nettype wire
